// ===== design/wgt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgt_pkg: shared types and constants for the Winograd F(2x2,3x3) tile unit
// Transform codes, result width and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package wgt_pkg;

  // Width of every result element.
  localparam int OUT_W = 26;

  // Transform selector, taken from the first row of a tile.
  typedef enum logic [1:0] {
    FUNC_INPUT  = 2'd0,
    FUNC_KERNEL = 2'd1,
    FUNC_OUTPUT = 2'd2,
    FUNC_UNUSED = 2'd3
  } func_t;

  // Last row index of an incoming tile, per transform.
  localparam logic [1:0] LAST_IN_ROW_KERNEL = 2'd2;
  localparam logic [1:0] LAST_IN_ROW_FULL   = 2'd3;

  // Last result row index, per transform.
  localparam logic [1:0] LAST_OUT_ROW_OUTPUT = 2'd1;
  localparam logic [1:0] LAST_OUT_ROW_FULL   = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       row_wr;    // store the incoming row
    logic [1:0] row_sel;   // tile row to store it in
    logic       col_load;  // compute the column pass for result row k
    logic       row_load;  // compute the row pass into the output register
    logic [1:0] k;         // result row index
    logic       last;      // result row k is the tile's last
    func_t      mode;      // transform of the current tile
  } wgt_cmd_t;

endpackage

// ===== design/wgt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgt_ctrl: tile sequencer for the Winograd tile unit
// Counts incoming rows, latches the transform and steps the result rows.
// ----------------------------------------------------------------------------
module wgt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output wgt_pkg::wgt_cmd_t cmd
);
  import wgt_pkg::*;

  typedef enum logic [3:0] {
    S_COLLECT = 4'b0001,
    S_COLUMN  = 4'b0010,
    S_ROW     = 4'b0100,
    S_EMIT    = 4'b1000
  } state_t;

  state_t     state;
  state_t     state_next;
  logic [1:0] rows_taken;
  logic [1:0] rows_taken_next;
  func_t      tile_mode;
  func_t      tile_mode_next;
  logic [1:0] k;
  logic [1:0] k_next;

  logic       in_acc;
  logic       first_row;
  func_t      eff_mode;
  logic       skip;
  logic [1:0] need_last;
  logic [1:0] last_k;
  logic       is_last;

  assign in_ready  = (state == S_COLLECT);
  assign out_valid = (state == S_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign first_row = (rows_taken == 2'd0);
  assign eff_mode  = first_row ? func_t'(func) : tile_mode;
  // A first row carrying the unused selector is dropped without effect.
  assign skip      = first_row && (func_t'(func) == FUNC_UNUSED);
  assign need_last = (eff_mode == FUNC_KERNEL) ? LAST_IN_ROW_KERNEL : LAST_IN_ROW_FULL;
  assign last_k    = (tile_mode == FUNC_OUTPUT) ? LAST_OUT_ROW_OUTPUT : LAST_OUT_ROW_FULL;
  assign is_last   = (k == last_k);

  always_comb begin
    state_next      = state;
    rows_taken_next = rows_taken;
    tile_mode_next  = tile_mode;
    k_next          = k;
    case (state)
      S_COLLECT: begin
        if (in_acc && !skip) begin
          tile_mode_next = eff_mode;
          if (rows_taken == need_last) begin
            rows_taken_next = 2'd0;
            k_next          = 2'd0;
            state_next      = S_COLUMN;
          end else begin
            rows_taken_next = rows_taken + 2'd1;
          end
        end
      end
      S_COLUMN: state_next = S_ROW;
      S_ROW:    state_next = S_EMIT;
      S_EMIT: begin
        if (out_ready) begin
          if (is_last) begin
            state_next = S_COLLECT;
          end else begin
            k_next     = k + 2'd1;
            state_next = S_COLUMN;
          end
        end
      end
      default: state_next = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_COLLECT;
      rows_taken <= 2'd0;
      tile_mode  <= FUNC_INPUT;
      k          <= 2'd0;
    end else begin
      state      <= state_next;
      rows_taken <= rows_taken_next;
      tile_mode  <= tile_mode_next;
      k          <= k_next;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.row_wr   = in_acc && !skip;
    cmd.row_sel  = rows_taken;
    cmd.col_load = (state == S_COLUMN);
    cmd.row_load = (state == S_ROW);
    cmd.k        = k;
    cmd.last     = is_last;
    cmd.mode     = tile_mode;
  end

endmodule

// ===== design/wgt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wgt_datapath: tile store and transform arithmetic
// Holds the tile, runs the column pass into a row register, then the row
// pass with bias and saturation into the output register.
// ----------------------------------------------------------------------------
module wgt_datapath #(
  parameter int DATA_WIDTH = 20
) (
  input  logic                                clk,
  input  logic                                rst,
  input  wgt_pkg::wgt_cmd_t                   cmd,
  input  logic signed [DATA_WIDTH-1:0]        row_elem_0,
  input  logic signed [DATA_WIDTH-1:0]        row_elem_1,
  input  logic signed [DATA_WIDTH-1:0]        row_elem_2,
  input  logic signed [DATA_WIDTH-1:0]        row_elem_3,
  input  logic                                cfg_wr,
  input  logic signed [wgt_pkg::OUT_W-1:0]    cfg_bias,
  output logic signed [wgt_pkg::OUT_W-1:0]    out_elem_0,
  output logic signed [wgt_pkg::OUT_W-1:0]    out_elem_1,
  output logic signed [wgt_pkg::OUT_W-1:0]    out_elem_2,
  output logic signed [wgt_pkg::OUT_W-1:0]    out_elem_3,
  output logic [1:0]                          out_row,
  output logic                                last_row
);
  import wgt_pkg::*;

  // Column pass results need two bits of growth, the row pass four more.
  localparam int TW = DATA_WIDTH + 2;
  localparam int IW = ((DATA_WIDTH + 6) > OUT_W ? (DATA_WIDTH + 6) : OUT_W) + 1;
  localparam logic signed [IW-1:0] SAT_HI = IW'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [IW-1:0] SAT_LO = -IW'(2 ** (OUT_W - 1));

  logic signed [DATA_WIDTH-1:0] tile_rows [4][4];
  logic signed [TW-1:0]         trow [4];
  logic signed [TW-1:0]         trow_next [4];
  logic signed [IW-1:0]         e [4];
  logic signed [OUT_W-1:0]      e_sat [4];
  logic signed [OUT_W-1:0]      bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias <= '0;
    end else if (cfg_wr) begin
      bias <= cfg_bias;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_wr) begin
      tile_rows[cmd.row_sel][0] <= row_elem_0;
      tile_rows[cmd.row_sel][1] <= row_elem_1;
      tile_rows[cmd.row_sel][2] <= row_elem_2;
      tile_rows[cmd.row_sel][3] <= row_elem_3;
    end
  end

  // Column pass: one row of the left transform applied to the tile.
  always_comb begin
    logic signed [TW-1:0] d0, d1, d2, d3;
    for (int j = 0; j < 4; j++) begin
      d0 = TW'(tile_rows[0][j]);
      d1 = TW'(tile_rows[1][j]);
      d2 = TW'(tile_rows[2][j]);
      d3 = TW'(tile_rows[3][j]);
      trow_next[j] = '0;
      case (cmd.mode)
        FUNC_INPUT: begin
          case (cmd.k)
            2'd0:    trow_next[j] = d0 - d2;
            2'd1:    trow_next[j] = d1 + d2;
            2'd2:    trow_next[j] = d2 - d1;
            default: trow_next[j] = d1 - d3;
          endcase
        end
        FUNC_KERNEL: begin
          // Twice G g, so the halves stay integral.
          case (cmd.k)
            2'd0:    trow_next[j] = d0 <<< 1;
            2'd1:    trow_next[j] = d0 + d1 + d2;
            2'd2:    trow_next[j] = d0 - d1 + d2;
            default: trow_next[j] = d2 <<< 1;
          endcase
        end
        FUNC_OUTPUT: begin
          case (cmd.k)
            2'd0:    trow_next[j] = d0 + d1 + d2;
            2'd1:    trow_next[j] = d1 - d2 - d3;
            default: trow_next[j] = '0;
          endcase
        end
        default: trow_next[j] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.col_load) begin
      for (int j = 0; j < 4; j++) begin
        trow[j] <= trow_next[j];
      end
    end
  end

  // Row pass: the right transform applied to the registered row.
  always_comb begin
    logic signed [IW-1:0] r0, r1, r2, r3, b;
    r0 = IW'(trow[0]);
    r1 = IW'(trow[1]);
    r2 = IW'(trow[2]);
    r3 = IW'(trow[3]);
    b  = IW'(bias);
    for (int j = 0; j < 4; j++) begin
      e[j] = '0;
    end
    case (cmd.mode)
      FUNC_INPUT: begin
        e[0] = (r0 - r2) <<< 2;
        e[1] = (r1 + r2) <<< 2;
        e[2] = (r2 - r1) <<< 2;
        e[3] = (r1 - r3) <<< 2;
      end
      FUNC_KERNEL: begin
        e[0] = r0 <<< 1;
        e[1] = r0 + r1 + r2;
        e[2] = r0 - r1 + r2;
        e[3] = r2 <<< 1;
      end
      FUNC_OUTPUT: begin
        e[0] = ((r0 + r1 + r2) <<< 2) + b;
        e[1] = ((r1 - r2 - r3) <<< 2) + b;
      end
      default: ;
    endcase
    for (int j = 0; j < 4; j++) begin
      if (e[j] > SAT_HI) begin
        e_sat[j] = OUT_W'(SAT_HI);
      end else if (e[j] < SAT_LO) begin
        e_sat[j] = OUT_W'(SAT_LO);
      end else begin
        e_sat[j] = OUT_W'(e[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_load) begin
      out_elem_0 <= e_sat[0];
      out_elem_1 <= e_sat[1];
      out_elem_2 <= e_sat[2];
      out_elem_3 <= e_sat[3];
      out_row    <= cmd.k;
      last_row   <= cmd.last;
    end
  end

endmodule

// ===== design/winograd_f23_tile_transform_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// winograd_f23_tile_transform_unit: Winograd F(2x2,3x3) tile transforms
// Input (B^T d B), kernel (G g G^T) and output (A^T m A + bias) transforms,
// all results scaled by four and saturated to 26 bits.
// ----------------------------------------------------------------------------
// Usage:
//   A tile enters one row per input transaction on in_valid/in_ready. The
//   func field of the tile's first row picks the transform and is ignored on
//   later rows; a first row with the unused selector is taken and dropped.
//   Input and output tiles have four rows, a kernel has three (row_elem_3 is
//   ignored). While a tile is being collected, in_ready stays high and one
//   row is taken every cycle that in_valid is high.
//   After the last row, the unit emits 4 result rows (2 for the output
//   transform) on out_valid/out_ready, tagged with out_row and last_row.
//   Each result row runs a column pass, registered in the S_COLUMN state, and
//   then a row pass with bias (output transform) and saturation, registered
//   in the S_ROW state, through separate add/subtract networks before
//   out_valid rises in S_EMIT; this follows the taking of the last input row
//   and of each earlier result row. Input is held off (in_ready low) until the last result
//   row of the tile has been taken; a stalled receiver simply holds the
//   current result in the output register.
//   output_bias is written on cfg_valid/cfg_ready, always ready, and must
//   only be changed between tiles. Reset clears the bias to zero and returns
//   the unit to waiting for the first row of a tile.
// ----------------------------------------------------------------------------
module winograd_f23_tile_transform_unit #(
  parameter int DATA_WIDTH = 20
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       func,
  input  logic signed [DATA_WIDTH-1:0]     row_elem_0,
  input  logic signed [DATA_WIDTH-1:0]     row_elem_1,
  input  logic signed [DATA_WIDTH-1:0]     row_elem_2,
  input  logic signed [DATA_WIDTH-1:0]     row_elem_3,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [wgt_pkg::OUT_W-1:0] out_elem_0,
  output logic signed [wgt_pkg::OUT_W-1:0] out_elem_1,
  output logic signed [wgt_pkg::OUT_W-1:0] out_elem_2,
  output logic signed [wgt_pkg::OUT_W-1:0] out_elem_3,
  output logic [1:0]                       out_row,
  output logic                             last_row,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic signed [wgt_pkg::OUT_W-1:0] output_bias
);
  import wgt_pkg::*;

  wgt_cmd_t cmd;

  // The bias register can take a write in any cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences rows and result rows; it sees no data.
  wgt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .func      (func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // The datapath stores the tile and computes one result row per command.
  wgt_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .row_elem_0 (row_elem_0),
    .row_elem_1 (row_elem_1),
    .row_elem_2 (row_elem_2),
    .row_elem_3 (row_elem_3),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_bias   (output_bias),
    .out_elem_0 (out_elem_0),
    .out_elem_1 (out_elem_1),
    .out_elem_2 (out_elem_2),
    .out_elem_3 (out_elem_3),
    .out_row    (out_row),
    .last_row   (last_row)
  );

  // Collection and emission never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  // The final result row of a tile is row 1 (output transform) or row 3.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_row) |-> (out_row == 2'd1 || out_row == 2'd3))
    else $error("last result row has an unexpected index");

  // Taking the final result row reopens the input side.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_row) |=> (in_ready && !out_valid))
    else $error("input not reopened after the tile's last result");

  // Taking a non-final row starts the next row's computation, not input.
  a_next_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_row) |=> (!in_ready && !out_valid))
    else $error("next result row not computed after a taken row");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for winograd_f23_tile_transform_unit
// Streams input, kernel and output tiles through the unit one row per
// transaction. A bit-exact predictor in the bench computes the expected
// result rows, and a monitor compares every result transaction field by
// field. The bias register is changed between phases, and both handshakes
// see random idle cycles, a stretch with no idling and a long receiver stall.
// ----------------------------------------------------------------------------
module tb;
  import wgt_pkg::*;

  localparam int DW          = 20;
  localparam int IDLE_PCT    = 26;    // idle cycles per hundred on each side
  localparam int LIMIT       = 2000;  // cycles with no transaction before giving up
  localparam int HOLD_LEN    = 64;    // length of the one long receiver stall
  localparam int HOLD_AT     = 150;   // result count that triggers that stall
  localparam int SETTLE      = 12;    // quiet cycles after the last result
  localparam int PHASE_ITEMS = 52;    // minimum counted rows per random phase

  localparam logic signed [DW-1:0]    ELEM_MAX = DW'((1 <<< (DW - 1)) - 1);
  localparam logic signed [DW-1:0]    ELEM_MIN = DW'(-(1 <<< (DW - 1)));
  localparam logic signed [OUT_W-1:0] OUT_MAX  = OUT_W'((1 <<< (OUT_W - 1)) - 1);
  localparam logic signed [OUT_W-1:0] OUT_MIN  = OUT_W'(-(1 <<< (OUT_W - 1)));

  // One row of a tile as it is offered to the unit.
  typedef struct {
    logic [1:0]            func;
    logic signed [DW-1:0]  e0, e1, e2, e3;
  } tile_row_t;

  // One expected result row.
  typedef struct {
    logic signed [OUT_W-1:0] e0, e1, e2, e3;
    logic [1:0]              row;
    logic                    last;
  } result_row_t;

  // Clock, reset and all inputs of the unit start at known values.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid   = 1'b0;
  logic                    in_ready;
  logic [1:0]              func       = '0;
  logic signed [DW-1:0]    row_elem_0 = '0;
  logic signed [DW-1:0]    row_elem_1 = '0;
  logic signed [DW-1:0]    row_elem_2 = '0;
  logic signed [DW-1:0]    row_elem_3 = '0;
  logic                    out_valid;
  logic                    out_ready  = 1'b0;
  logic signed [OUT_W-1:0] out_elem_0;
  logic signed [OUT_W-1:0] out_elem_1;
  logic signed [OUT_W-1:0] out_elem_2;
  logic signed [OUT_W-1:0] out_elem_3;
  logic [1:0]              out_row;
  logic                    last_row;
  logic                    cfg_valid   = 1'b0;
  logic                    cfg_ready;
  logic signed [OUT_W-1:0] output_bias = '0;

  always #10 clk = ~clk;

  winograd_f23_tile_transform_unit #(
    .DATA_WIDTH (DW)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .row_elem_0  (row_elem_0),
    .row_elem_1  (row_elem_1),
    .row_elem_2  (row_elem_2),
    .row_elem_3  (row_elem_3),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_elem_0  (out_elem_0),
    .out_elem_1  (out_elem_1),
    .out_elem_2  (out_elem_2),
    .out_elem_3  (out_elem_3),
    .out_row     (out_row),
    .last_row    (last_row),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .output_bias (output_bias)
  );

  // Rows waiting to be offered, and result rows the unit still owes us.
  tile_row_t   row_queue[$];
  result_row_t expected_rows[$];
  tile_row_t   drive_row;

  // Private copy of the unit's state as the predictor sees it.
  logic signed [DW-1:0]    tile_store [16];
  logic [1:0]              rows_taken = '0;
  func_t                   tile_mode  = FUNC_INPUT;
  logic signed [OUT_W-1:0] bias_model = '0;

  // Bookkeeping for the report.
  int  mismatches     = 0;
  int  results_seen   = 0;
  int  rows_accepted  = 0;
  int  dropped_rows   = 0;
  int  bias_writes    = 0;
  int  tiles_of[3]    = '{0, 0, 0};
  int  quiet          = 0;
  int  hold_left      = 0;
  bit  hold_done      = 1'b0;
  bit  steady         = 1'b0;    // no idling on either side while set

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Clamp a wide intermediate to the signed result range.
  function automatic logic signed [OUT_W-1:0] clamp_out(longint x);
    if (x > longint'(OUT_MAX)) return OUT_MAX;
    if (x < longint'(OUT_MIN)) return OUT_MIN;
    return x[OUT_W-1:0];
  endfunction

  task automatic push_result(int k, longint a, longint b, longint c, longint d, bit last);
    result_row_t r;
    r.e0   = clamp_out(a);
    r.e1   = clamp_out(b);
    r.e2   = clamp_out(c);
    r.e3   = clamp_out(d);
    r.row  = k[1:0];
    r.last = last;
    expected_rows.push_back(r);
  endtask

  // Runs the transform of the completed tile and queues its result rows.
  // All math is done on 64-bit integers, with every result scaled by four.
  task automatic finish_tile();
    longint d[16];
    longint t[16];
    longint a, b, c, bias;
    int     r;
    for (int i = 0; i < 16; i++) d[i] = longint'(tile_store[i]);
    bias = longint'(bias_model);
    case (tile_mode)
      FUNC_INPUT: begin
        // Column pass B^T d, then row pass times B.
        for (int j = 0; j < 4; j++) begin
          t[j]      = d[j] - d[8 + j];
          t[4 + j]  = d[4 + j] + d[8 + j];
          t[8 + j]  = d[8 + j] - d[4 + j];
          t[12 + j] = d[4 + j] - d[12 + j];
        end
        for (int i = 0; i < 4; i++) begin
          r = 4 * i;
          push_result(i, 4 * (t[r] - t[r + 2]), 4 * (t[r + 1] + t[r + 2]),
                      4 * (t[r + 2] - t[r + 1]), 4 * (t[r + 1] - t[r + 3]), i == 3);
        end
      end
      FUNC_KERNEL: begin
        // Twice G g, stored as four rows of three; the second pass doubles again.
        for (int j = 0; j < 3; j++) begin
          a = d[j];
          b = d[4 + j];
          c = d[8 + j];
          t[j]     = 2 * a;
          t[3 + j] = a + b + c;
          t[6 + j] = a - b + c;
          t[9 + j] = 2 * c;
        end
        for (int i = 0; i < 4; i++) begin
          r = 3 * i;
          push_result(i, 2 * t[r], t[r] + t[r + 1] + t[r + 2],
                      t[r] - t[r + 1] + t[r + 2], 2 * t[r + 2], i == 3);
        end
      end
      default: begin
        // Output transform: two result rows of two elements, plus the bias.
        for (int j = 0; j < 4; j++) begin
          t[j]     = d[j] + d[4 + j] + d[8 + j];
          t[4 + j] = d[4 + j] - d[8 + j] - d[12 + j];
        end
        for (int i = 0; i < 2; i++) begin
          r = 4 * i;
          push_result(i, 4 * (t[r] + t[r + 1] + t[r + 2]) + bias,
                      4 * (t[r + 1] - t[r + 2] - t[r + 3]) + bias, 0, 0, i == 1);
        end
      end
    endcase
  endtask

  // Folds one accepted input row into the predicted state.
  task automatic absorb_row(logic [1:0] f, logic signed [DW-1:0] a, logic signed [DW-1:0] b,
                            logic signed [DW-1:0] c, logic signed [DW-1:0] d);
    logic [1:0] need;
    if (rows_taken == 2'd0) begin
      // The unused selector on a first row is dropped without a trace.
      if (f == FUNC_UNUSED) begin
        dropped_rows++;
        return;
      end
      tile_mode = func_t'(f);
    end
    rows_accepted++;
    tile_store[4 * rows_taken]     = a;
    tile_store[4 * rows_taken + 1] = b;
    tile_store[4 * rows_taken + 2] = c;
    tile_store[4 * rows_taken + 3] = d;
    need = (tile_mode == FUNC_KERNEL) ? LAST_IN_ROW_KERNEL : LAST_IN_ROW_FULL;
    if (rows_taken != need) begin
      rows_taken = rows_taken + 2'd1;
    end else begin
      rows_taken = 2'd0;
      tiles_of[tile_mode]++;
      finish_tile();
    end
  endtask

  // Compares one result transaction with the oldest expected row.
  task automatic check_result();
    result_row_t want;
    results_seen++;
    if (expected_rows.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] result row %0d with nothing expected: %0d %0d %0d %0d last %0b",
                 $realtime, out_row, out_elem_0, out_elem_1, out_elem_2, out_elem_3, last_row);
      return;
    end
    want = expected_rows.pop_front();
    if (out_elem_0 !== want.e0 || out_elem_1 !== want.e1 || out_elem_2 !== want.e2 ||
        out_elem_3 !== want.e3 || out_row !== want.row || last_row !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("[%0t] mismatch: got %0d %0d %0d %0d row %0d last %0b", $realtime,
                 out_elem_0, out_elem_1, out_elem_2, out_elem_3, out_row, last_row);
        $display("             want %0d %0d %0d %0d row %0d last %0b",
                 want.e0, want.e1, want.e2, want.e3, want.row, want.last);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers queued rows. A new row is only loaded once the current
  // transaction has completed, so valid and payload stay put while stalled.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (row_queue.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        drive_row = row_queue.pop_front();
        in_valid   <= 1'b1;
        func       <= drive_row.func;
        row_elem_0 <= drive_row.e0;
        row_elem_1 <= drive_row.e1;
        row_elem_2 <= drive_row.e2;
        row_elem_3 <= drive_row.e3;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus one long stall counted here so the
  // unit fills up and holds its input off while the driver keeps offering.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: samples every transaction at the clock edge. Results are checked
  // before the row taken at the same edge is predicted; a tile's first result
  // can never come out at the edge that takes its last row.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) absorb_row(func, row_elem_0, row_elem_1, row_elem_2, row_elem_3);
      if (cfg_valid && cfg_ready) begin
        bias_model = output_bias;
        bias_writes++;
      end
    end
  end

  // Watchdog: a correct run never goes this long without some transaction.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $realtime, LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic logic signed [DW-1:0] pick_elem(int style);
    case (style)
      0: return DW'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return ELEM_MAX;
          1: return ELEM_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return DW'(int'($urandom_range(16)) - 8);
    endcase
  endfunction

  function automatic void add_row(logic [1:0] f, logic signed [DW-1:0] a,
                                  logic signed [DW-1:0] b, logic signed [DW-1:0] c,
                                  logic signed [DW-1:0] d);
    tile_row_t r;
    r.func = f;
    r.e0   = a;
    r.e1   = b;
    r.e2   = c;
    r.e3   = d;
    row_queue.push_back(r);
  endfunction

  function automatic int rows_for(func_t f);
    return (f == FUNC_KERNEL) ? 3 : 4;
  endfunction

  // Every element the same; later rows carry another selector, which the
  // unit must ignore once a tile has started.
  task automatic add_flat_tile(func_t f, func_t later, logic signed [DW-1:0] v);
    for (int r = 0; r < rows_for(f); r++) add_row(r == 0 ? f : later, v, v, v, v);
  endtask

  // Alternating extremes in a checkerboard.
  task automatic add_checker_tile(func_t f, func_t later);
    logic signed [DW-1:0] p, q;
    for (int r = 0; r < rows_for(f); r++) begin
      p = r[0] ? ELEM_MIN : ELEM_MAX;
      q = r[0] ? ELEM_MAX : ELEM_MIN;
      add_row(r == 0 ? f : later, p, q, p, q);
    end
  endtask

  // A well-formed tile with random content; returns the rows it queued.
  function automatic int add_random_tile();
    func_t      f;
    logic [1:0] rf;
    int         style, pick;
    f = func_t'($urandom_range(2));
    pick = $urandom_range(99);
    style = (pick < 60) ? 0 : (pick < 85) ? 1 : 2;
    for (int r = 0; r < rows_for(f); r++) begin
      rf = (r == 0 || $urandom_range(99) < 70) ? f : 2'($urandom_range(3));
      add_row(rf, pick_elem(style), pick_elem(style), pick_elem(style), pick_elem(style));
    end
    return rows_for(f);
  endfunction

  // Sender pause: nothing new is offered until every owed result has been
  // taken, and then a few quiet cycles let the unit settle.
  task automatic drain();
    while (row_queue.size() != 0 || in_valid || cfg_valid || expected_rows.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Bias write, only ever issued while the unit sits between tiles.
  task automatic write_bias(logic signed [OUT_W-1:0] v);
    @(posedge clk);
    cfg_valid   <= 1'b1;
    output_bias <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(logic signed [OUT_W-1:0] bias, bit calm);
    int made;
    write_bias(bias);
    steady = calm;
    made = 0;
    while (made < PHASE_ITEMS) begin
      // Now and then a stray first row with the unused selector.
      if ($urandom_range(99) < 8)
        add_row(FUNC_UNUSED, pick_elem(0), pick_elem(0), pick_elem(0), pick_elem(0));
      else
        made += add_random_tile();
    end
    drain();
    steady = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset bias: each transform at the extremes, a
    // stray unused selector, and selector changes in the middle of tiles.
    add_flat_tile(FUNC_INPUT, FUNC_INPUT, ELEM_MAX);
    add_checker_tile(FUNC_KERNEL, FUNC_UNUSED);
    add_row(FUNC_UNUSED, ELEM_MAX, ELEM_MIN, '0, '1);
    add_flat_tile(FUNC_INPUT, FUNC_OUTPUT, ELEM_MIN);
    add_checker_tile(FUNC_OUTPUT, FUNC_KERNEL);
    drain();

    // Saturation of the output transform at both ends of the bias range.
    write_bias(OUT_MAX);
    add_flat_tile(FUNC_OUTPUT, FUNC_OUTPUT, ELEM_MAX);
    drain();
    write_bias(OUT_MIN);
    add_flat_tile(FUNC_OUTPUT, FUNC_INPUT, ELEM_MIN);
    drain();

    // Random phases, each at its own bias; one runs without any idling.
    run_random_phase(OUT_W'($urandom), 1'b0);
    run_random_phase('0, 1'b1);
    run_random_phase(OUT_W'(int'($urandom_range(2000)) - 1000), 1'b0);
    run_random_phase(OUT_MAX, 1'b0);
    run_random_phase(OUT_MIN, 1'b0);
    run_random_phase('1, 1'b0);

    $display("Tiles run: %0d input, %0d kernel, %0d output (%0d rows, %0d stray rows dropped)",
             tiles_of[FUNC_INPUT], tiles_of[FUNC_KERNEL], tiles_of[FUNC_OUTPUT],
             rows_accepted, dropped_rows);
    $display("Result rows checked: %0d over %0d bias settings; mismatches: %0d",
             results_seen, bias_writes, mismatches);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
